// ===== sv/http_request_header_tokenizer_macros.svh =====
// Assertion macros used by the tokenizer RTL.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrht assertion failed");

// Next-cycle implication, checked outside reset.
`define HRHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrht assertion failed");

`endif

// ===== sv/hrht_pkg.sv =====
package hrht_pkg;

   // Parse phases
   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_PATH    = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_NAME    = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;
   localparam logic [2:0] PH_FAILED  = 3'd6;

   // Byte kinds (also used for the closed token)
   localparam logic [2:0] KIND_DROP    = 3'd0;
   localparam logic [2:0] KIND_METHOD  = 3'd1;
   localparam logic [2:0] KIND_PATH    = 3'd2;
   localparam logic [2:0] KIND_VERSION = 3'd3;
   localparam logic [2:0] KIND_NAME    = 3'd4;
   localparam logic [2:0] KIND_VALUE   = 3'd5;
   localparam logic [2:0] KIND_BODY    = 3'd6;

   localparam logic [2:0] PREFIX_LEN = 3'd5;

   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_COLON = 8'h3A;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_HIGH  = 8'h80;

   typedef struct packed {
      logic [2:0] phase;
      logic       pending_cr;
      logic       token_nonempty;
      logic [2:0] prefix_count;
      logic       prefix_mismatch;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_METHOD, pending_cr: 1'b0, token_nonempty: 1'b0,
      prefix_count: 3'd0, prefix_mismatch: 1'b0};

   typedef struct packed {
      logic       bad_request;
      logic       header_done;
      logic [2:0] closed_kind;
      logic [2:0] byte_kind;
   } result_type;

   // Expected version prefix "HTTP/"
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] chr;
      case (idx)
         3'd0: chr = 8'h48;
         3'd1: chr = 8'h54;
         3'd2: chr = 8'h54;
         3'd3: chr = 8'h50;
         3'd4: chr = 8'h2F;
         default: chr = 8'h00;
      endcase
      return chr;
   endfunction

endpackage

// ===== sv/http_request_header_tokenizer.sv =====
// Channel   Dir  Beat fields (low bit first)
// req_      in   tdata: data_byte[7:0]; tuser: first_of_request
// rsp_      out  tdata: byte_value[7:0];
//                tuser: byte_kind[2:0], closed_kind[5:3], header_done[6], bad_request[7]
//
// One byte per cycle sustained while rsp is not stalled; a req beat is taken into the
// input register, then passes through the step logic into the result register, which
// offers it on rsp. The combinational parse update in the step logic sets the rate.
// Synchronous active-high reset returns the parser to the method phase and empties
// both registers. A stalled rsp holds its beat; the input register keeps taking
// beats while the result register can move on in the same cycle.
`include "http_request_header_tokenizer_macros.svh"

module http_request_header_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] first_of_request
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_value
   output logic [7:0] rsp_tuser    // [2:0] byte_kind, [5:3] closed_kind,
                                   // [6] header_done, [7] bad_request
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_first_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff;
   hrht_pkg::result_type out_res_ff;
   hrht_pkg::state_type  state_ff, state_in;
   hrht_pkg::result_type step_res;
   logic                 advance;

   // input stage moves to the result stage when the result slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   hrht_step u_step (
      .state_cur        (state_ff),
      .data_byte        (in_byte_ff),
      .first_of_request (in_first_ff),
      .state_nxt        (state_in),
      .result           (step_res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hrht_pkg::STATE_RESET;
      end else begin
         if (req_tready)
            in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance)
            state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
      if (advance) begin
         out_byte_ff <= in_byte_ff;
         out_res_ff  <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_res_ff.bad_request, out_res_ff.header_done,
                        out_res_ff.closed_kind, out_res_ff.byte_kind};

   // checks
   `HRHT_ASSERT_NEXT(a_done_enters_body, clock, reset, advance && step_res.header_done,
                     state_ff.phase == hrht_pkg::PH_BODY)
   `HRHT_ASSERT_NEXT(a_bad_is_failed, clock, reset, advance && step_res.bad_request,
                     state_ff.phase == hrht_pkg::PH_FAILED)
   `HRHT_ASSERT_NOW(a_bad_drops, clock, reset, rsp_tvalid && rsp_tuser[7],
                    rsp_tuser[2:0] == hrht_pkg::KIND_DROP)

endmodule

// ===== sv/hrht_step.sv =====
module hrht_step (
   input  hrht_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 first_of_request,
   output hrht_pkg::state_type  state_nxt,
   output hrht_pkg::result_type result
);

   hrht_pkg::state_type cur;
   logic                keep;
   logic                blank;

   // blank: space, tab, LF, VT, FF, CR
   assign blank = (data_byte == hrht_pkg::CHR_SPACE) ||
                  ((data_byte >= hrht_pkg::CHR_TAB) && (data_byte <= hrht_pkg::CHR_CR));

   // Phase update and byte tagging
   always_comb begin
      cur       = first_of_request ? hrht_pkg::STATE_RESET : state_cur;
      state_nxt = cur;
      keep      = 1'b0;
      result.byte_kind   = hrht_pkg::KIND_DROP;
      result.closed_kind = hrht_pkg::KIND_DROP;
      result.header_done = 1'b0;

      if (cur.phase == hrht_pkg::PH_BODY) begin
         result.byte_kind     = hrht_pkg::KIND_BODY;
         state_nxt.pending_cr = 1'b0;
      end else if (cur.phase > hrht_pkg::PH_BODY) begin
         state_nxt.phase      = hrht_pkg::PH_FAILED;
         state_nxt.pending_cr = 1'b0;
      end else if (cur.pending_cr && (data_byte == hrht_pkg::CHR_LF)) begin
         // line end
         state_nxt.pending_cr = 1'b0;
         case (cur.phase)
            hrht_pkg::PH_VERSION: begin
               result.closed_kind       = hrht_pkg::KIND_VERSION;
               state_nxt.token_nonempty = 1'b0;
               if ((cur.prefix_count < hrht_pkg::PREFIX_LEN) || cur.prefix_mismatch)
                  state_nxt.phase = hrht_pkg::PH_FAILED;
               else
                  state_nxt.phase = hrht_pkg::PH_NAME;
            end
            hrht_pkg::PH_VALUE: begin
               result.closed_kind       = hrht_pkg::KIND_VALUE;
               state_nxt.token_nonempty = 1'b0;
               state_nxt.phase          = hrht_pkg::PH_NAME;
            end
            hrht_pkg::PH_NAME: begin
               result.header_done       = 1'b1;
               state_nxt.token_nonempty = 1'b0;
               state_nxt.phase          = hrht_pkg::PH_BODY;
            end
            default: begin
            end
         endcase
      end else if (data_byte == hrht_pkg::CHR_CR) begin
         state_nxt.pending_cr = 1'b1;
      end else begin
         state_nxt.pending_cr = 1'b0;
         if (data_byte < hrht_pkg::CHR_HIGH && blank) begin
            if (cur.phase == hrht_pkg::PH_METHOD) begin
               result.closed_kind       = hrht_pkg::KIND_METHOD;
               state_nxt.token_nonempty = 1'b0;
               state_nxt.phase          = hrht_pkg::PH_PATH;
            end else if (cur.phase == hrht_pkg::PH_PATH) begin
               result.closed_kind        = hrht_pkg::KIND_PATH;
               state_nxt.token_nonempty  = 1'b0;
               state_nxt.prefix_count    = 3'd0;
               state_nxt.prefix_mismatch = 1'b0;
               state_nxt.phase           = hrht_pkg::PH_VERSION;
            end else if (cur.phase != hrht_pkg::PH_VERSION && cur.token_nonempty) begin
               keep = 1'b1;
            end
         end else if (cur.phase == hrht_pkg::PH_NAME && data_byte == hrht_pkg::CHR_COLON) begin
            result.closed_kind       = hrht_pkg::KIND_NAME;
            state_nxt.token_nonempty = 1'b0;
            state_nxt.phase          = hrht_pkg::PH_VALUE;
         end else begin
            keep = 1'b1;
         end
      end

      // kept byte: kind follows phase, version bytes feed the prefix check
      if (keep) begin
         result.byte_kind         = cur.phase + 3'd1;
         state_nxt.token_nonempty = 1'b1;
         if (cur.phase == hrht_pkg::PH_VERSION && cur.prefix_count < hrht_pkg::PREFIX_LEN) begin
            if (data_byte != hrht_pkg::prefix_char(cur.prefix_count))
               state_nxt.prefix_mismatch = 1'b1;
            state_nxt.prefix_count = cur.prefix_count + 3'd1;
         end
      end

      result.bad_request = (state_nxt.phase == hrht_pkg::PH_FAILED);
   end

endmodule

// ===== tb/sv/tb_http_request_header_tokenizer.sv =====
module tb_http_request_header_tokenizer;

   // "HTTP/" packed with the first character in the top byte
   localparam logic [39:0] VERSION_TAG = "HTTP/";

   // One tagged byte as the block should report it
   typedef struct packed {
      logic [7:0] value;
      logic [2:0] kind;
      logic [2:0] closed;
      logic       done;
      logic       bad;
   } byte_tag_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tuser = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [7:0] rsp_tuser;

   // Parser state mirrored by the predictor
   logic [2:0] tok_phase = hrht_pkg::PH_METHOD;
   logic       tok_pending_cr = 1'b0;
   logic       tok_nonempty = 1'b0;
   logic [2:0] tok_prefix_count = 3'd0;
   logic       tok_prefix_bad = 1'b0;

   byte_tag_type expected_tags[$];
   int           error_count = 0;
   int           src_idle_pct = 0;
   int           snk_stall_pct = 0;

   http_request_header_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
   end

   // Tag one accepted byte and queue the expected result beat
   task automatic tokenize_byte(input logic [7:0] c, input logic first);
      logic [2:0]   kind;
      logic [2:0]   closed;
      logic         done;
      logic         keep;
      logic         blank;
      byte_tag_type tag;
      kind   = hrht_pkg::KIND_DROP;
      closed = hrht_pkg::KIND_DROP;
      done   = 1'b0;
      keep   = 1'b0;
      blank  = !c[7] && (c == hrht_pkg::CHR_SPACE ||
                         (c >= hrht_pkg::CHR_TAB && c <= hrht_pkg::CHR_CR));
      if (first) begin
         tok_phase        = hrht_pkg::PH_METHOD;
         tok_pending_cr   = 1'b0;
         tok_nonempty     = 1'b0;
         tok_prefix_count = 3'd0;
         tok_prefix_bad   = 1'b0;
      end
      if (tok_phase == hrht_pkg::PH_BODY) begin
         kind = hrht_pkg::KIND_BODY;
         tok_pending_cr = 1'b0;
      end else if (tok_phase > hrht_pkg::PH_BODY) begin
         tok_phase = hrht_pkg::PH_FAILED;
         tok_pending_cr = 1'b0;
      end else if (tok_pending_cr && c == hrht_pkg::CHR_LF) begin
         // line end
         tok_pending_cr = 1'b0;
         case (tok_phase)
            hrht_pkg::PH_VERSION: begin
               closed = hrht_pkg::KIND_VERSION;
               tok_nonempty = 1'b0;
               tok_phase = (tok_prefix_count < hrht_pkg::PREFIX_LEN || tok_prefix_bad) ?
                           hrht_pkg::PH_FAILED : hrht_pkg::PH_NAME;
            end
            hrht_pkg::PH_VALUE: begin
               closed = hrht_pkg::KIND_VALUE;
               tok_nonempty = 1'b0;
               tok_phase = hrht_pkg::PH_NAME;
            end
            hrht_pkg::PH_NAME: begin
               done = 1'b1;
               tok_nonempty = 1'b0;
               tok_phase = hrht_pkg::PH_BODY;
            end
            default: ;
         endcase
      end else if (c == hrht_pkg::CHR_CR) begin
         tok_pending_cr = 1'b1;
      end else begin
         tok_pending_cr = 1'b0;
         if (blank) begin
            if (tok_phase == hrht_pkg::PH_METHOD) begin
               closed = hrht_pkg::KIND_METHOD;
               tok_nonempty = 1'b0;
               tok_phase = hrht_pkg::PH_PATH;
            end else if (tok_phase == hrht_pkg::PH_PATH) begin
               closed = hrht_pkg::KIND_PATH;
               tok_nonempty = 1'b0;
               tok_prefix_count = 3'd0;
               tok_prefix_bad = 1'b0;
               tok_phase = hrht_pkg::PH_VERSION;
            end else if (tok_phase != hrht_pkg::PH_VERSION && tok_nonempty) begin
               keep = 1'b1;
            end
         end else if (tok_phase == hrht_pkg::PH_NAME && c == hrht_pkg::CHR_COLON) begin
            closed = hrht_pkg::KIND_NAME;
            tok_nonempty = 1'b0;
            tok_phase = hrht_pkg::PH_VALUE;
         end else begin
            keep = 1'b1;
         end
      end
      if (keep) begin
         // kind codes sit one above the phase codes
         kind = tok_phase + 3'd1;
         tok_nonempty = 1'b1;
         if (tok_phase == hrht_pkg::PH_VERSION && tok_prefix_count < hrht_pkg::PREFIX_LEN) begin
            if (c != VERSION_TAG[8 * (4 - tok_prefix_count) +: 8])
               tok_prefix_bad = 1'b1;
            tok_prefix_count = tok_prefix_count + 3'd1;
         end
      end
      tag.value  = c;
      tag.kind   = kind;
      tag.closed = closed;
      tag.done   = done;
      tag.bad    = (tok_phase == hrht_pkg::PH_FAILED);
      expected_tags.push_back(tag);
   endtask

   // Result check against the oldest expected beat
   always @(posedge clock) begin : check_rsp
      byte_tag_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tags.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected rsp beat: tdata=%h tuser=%h", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_tags.pop_front();
            if (rsp_tdata != want.value || rsp_tuser[2:0] != want.kind ||
                rsp_tuser[5:3] != want.closed || rsp_tuser[6] != want.done ||
                rsp_tuser[7] != want.bad) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: exp byte=%h kind=%0d closed=%0d done=%b bad=%b",
                           want.value, want.kind, want.closed, want.done, want.bad);
                  $display("          got byte=%h kind=%0d closed=%0d done=%b bad=%b",
                           rsp_tdata, rsp_tuser[2:0], rsp_tuser[5:3], rsp_tuser[6],
                           rsp_tuser[7]);
               end
            end
         end
      end
   end

   // Send one beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [7:0] b, input logic first);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tokenize_byte(b, first);
   endtask

   task automatic send_text(input string s, input logic first);
      for (int i = 0; i < s.len(); i++)
         send_beat(s[i], first && i == 0);
   endtask

   task automatic wait_for_results();
      while (expected_tags.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_token_char(input bit allow_colon);
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0) begin
         c = 8'($urandom_range(8'h80, 8'hFF));
      end else begin
         c = 8'($urandom_range(8'h21, 8'h7E));
         if (!allow_colon && c == hrht_pkg::CHR_COLON)
            c = 8'h2D;
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_blank();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0: c = hrht_pkg::CHR_TAB;
         1: c = 8'h0B;
         2: c = 8'h0C;
         default: c = hrht_pkg::CHR_SPACE;
      endcase
      return c;
   endfunction

   // High bytes, good request with header and body, leading blanks,
   // colon inside a value, then a bad version prefix and the failed state
   task automatic test_directed_requests();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      send_beat("G", 1'b1);
      send_beat(8'h80, 1'b0);
      send_text(" /", 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text(" HTTP/\r\n x: :\r\n\r\n\r", 1'b0);
      send_beat(8'h00, 1'b0);
      send_text("a b c\r\nz", 1'b1);
   endtask

   // Mostly well-formed requests with random content, some noise
   task automatic test_random_requests(input int beats, input int idle_pct,
                                       input int stall_pct);
      logic [7:0] req_bytes[$];
      int         n;
      int         hdrs;
      int         sent;
      logic       first;
      src_idle_pct  = idle_pct;
      snk_stall_pct = stall_pct;
      sent = 0;
      while (sent < beats) begin
         req_bytes.delete();
         if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            // request line
            n = $urandom_range(1, 4);
            repeat (n) req_bytes.push_back(pick_token_char(1));
            req_bytes.push_back(pick_blank());
            n = $urandom_range(1, 4);
            repeat (n) req_bytes.push_back(pick_token_char(1));
            req_bytes.push_back(pick_blank());
            if ($urandom_range(0, 3) != 0) begin
               for (int i = 0; i < 5; i++)
                  req_bytes.push_back(VERSION_TAG[8 * (4 - i) +: 8]);
               n = $urandom_range(0, 3);
               repeat (n) req_bytes.push_back(8'($urandom_range(8'h2E, 8'h39)));
            end else begin
               n = $urandom_range(1, 6);
               repeat (n) req_bytes.push_back(pick_token_char(1));
            end
            req_bytes.push_back(hrht_pkg::CHR_CR);
            req_bytes.push_back(hrht_pkg::CHR_LF);
            // header lines
            hdrs = $urandom_range(0, 3);
            repeat (hdrs) begin
               if ($urandom_range(0, 3) == 0) req_bytes.push_back(pick_blank());
               n = $urandom_range(1, 4);
               repeat (n) req_bytes.push_back(pick_token_char(0));
               req_bytes.push_back(hrht_pkg::CHR_COLON);
               n = $urandom_range(0, 2);
               repeat (n) req_bytes.push_back(pick_blank());
               n = $urandom_range(0, 4);
               repeat (n)
                  req_bytes.push_back(($urandom_range(0, 4) == 0) ?
                                      pick_blank() : pick_token_char(1));
               req_bytes.push_back(hrht_pkg::CHR_CR);
               req_bytes.push_back(hrht_pkg::CHR_LF);
            end
            req_bytes.push_back(hrht_pkg::CHR_CR);
            req_bytes.push_back(hrht_pkg::CHR_LF);
            // body
            n = $urandom_range(0, 4);
            repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
         end
         foreach (req_bytes[i]) begin
            first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            if ($urandom_range(0, 29) == 0)
               send_beat(8'($urandom_range(0, 255)), first);
            else
               send_beat(req_bytes[i], first);
            sent++;
         end
      end
   endtask

   // Sender holds off until the pipeline has drained, then resumes
   task automatic test_pause_until_drained();
      src_idle_pct  = 10;
      snk_stall_pct = 10;
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait_for_results();
      send_text("PUT /q HTTP/2\r\nk:v\r\n\r\nxy", 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_requests();
      test_random_requests(125, 0, 0);
      test_random_requests(125, 49, 0);
      test_pause_until_drained();
      test_random_requests(125, 0, 49);
      test_random_requests(125, 10, 10);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait_for_results();
      repeat (10) @(posedge clock);
      error_count += expected_tags.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
